/* rtl/software_timer_bank_top_defines.svh */
// Assertion helpers for the timer bank checker
`ifndef SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_TOP_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, idle in reset
`define STB_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STB_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stb_pkg.sv */
package stb_pkg;

    // most fired beats reported for one tick
    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_KILL    = 2'd2,
        ACT_QUERY   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef enum logic [0:0] {
        CFG_TIMERS_IN_USE = 1'b0,
        CFG_TICK_STEP     = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [31:0] timer_id;
        logic [31:0] start_value;
        logic [31:0] cycle_value;
    } t_in_beat;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] which_timer;
        logic       alive;
        logic       last;
    } t_out_beat;

    // one timer's state as it travels around the ring
    typedef struct packed {
        logic        armed;
        logic [31:0] remaining;
        logic [31:0] reload;
    } t_slot;

    // control for the update unit at the head of the ring
    typedef struct packed {
        t_action action;
        logic    hit;
        logic    in_use;
    } t_head_ctl;

endpackage

/* rtl/stb_stream_if.sv */
interface stb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/software_timer_bank_top.sv */
// Every item makes one full turn of the timer ring, one slot a cycle unless a fired beat waits on a stalled output.
// The final result of an item is registered once the turn has ended (earlier fired beats of a
// tick leave when the next firing is found).
// A new item is taken only after the final result of the previous one has been registered.
// Reset (synchronous, active low): all timers disarmed, timers_in_use = 16,
// tick_step = 1, output empty.
module software_timer_bank_top
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stb_stream_if.sink   i_in,
    stb_stream_if.source o_out,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_step;
    t_action          r_action;
    logic             r_id_ok;
    logic [IDX_W-1:0] r_slot;
    logic [31:0]      r_start;
    logic [31:0]      r_cycle;
    logic             r_alive;
    logic             r_held_valid;
    logic [3:0]       r_held_idx;
    logic [RES_W-1:0] r_count;
    logic [4:0]       r_tiu;
    logic [31:0]      r_tick_step;
    logic             r_out_valid;
    t_out_beat        r_out;

    t_slot     w_cell_q [NUM_TIMERS];
    t_slot     w_head_d;
    t_head_ctl w_ctl;
    logic      w_fire;
    logic      w_in_ready;
    logic      w_run;
    logic      w_done;
    logic      w_accept;
    logic      w_out_free;
    logic      w_record;
    logic      w_emit_held;
    logic      w_shift;
    logic      w_last_step;
    logic      w_push_final;
    logic [31:0] w_step32;
    logic [31:0] w_id;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu       <= 5'd16;
            r_tick_step <= 32'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMERS_IN_USE: r_tiu       <= i_cfg_data[4:0];
                CFG_TICK_STEP:     r_tick_step <= i_cfg_data;
                default:           r_tiu       <= r_tiu;
            endcase
        end
    end

    // ring of timer cells, head output goes through the update unit to the tail
    genvar k;
    generate
        for (k = 0; k < NUM_TIMERS; k++) begin : g_cell
            if (k == NUM_TIMERS - 1) begin : g_tail
                stb_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_slot  (w_head_d),
                    .o_slot  (w_cell_q[k])
                );
            end else begin : g_body
                stb_cell u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_shift),
                    .i_slot  (w_cell_q[k+1]),
                    .o_slot  (w_cell_q[k])
                );
            end
        end
    endgenerate

    assign w_step32 = 32'(r_step);
    assign w_id     = i_in.payload.timer_id;

    assign w_ctl.action = r_action;
    assign w_ctl.hit    = r_id_ok && (r_slot == r_step);
    assign w_ctl.in_use = (w_step32 < 32'(r_tiu));

    stb_proc u_proc (
        .i_ctl         (w_ctl),
        .i_slot        (w_cell_q[0]),
        .i_tick_step   (r_tick_step),
        .i_start_value (r_start),
        .i_cycle_value (r_cycle),
        .o_slot        (w_head_d),
        .o_fire        (w_fire)
    );

    // handshake and step control
    assign w_accept     = i_in.valid && w_in_ready;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_record     = w_run && w_fire && (r_count < RES_W'(MAX_RESULTS));
    assign w_emit_held  = w_record && r_held_valid && w_out_free;
    assign w_shift      = w_run && (!(w_record && r_held_valid) || w_out_free);
    assign w_last_step  = (r_step == IDX_W'(NUM_TIMERS - 1));
    assign w_push_final = w_done && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_RUN;
            ST_RUN:  if (w_shift && w_last_step) n_state = ST_DONE;
            ST_DONE: if (w_push_final) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        w_in_ready = 1'b0;
        w_run      = 1'b0;
        w_done     = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_RUN:  w_run      = 1'b1;
            ST_DONE: w_done     = 1'b1;
            default: w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item capture and per-turn bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_held_valid <= 1'b0;
            r_count      <= '0;
            r_alive      <= 1'b0;
        end else if (w_accept) begin
            r_step       <= '0;
            r_held_valid <= 1'b0;
            r_count      <= '0;
            r_alive      <= 1'b0;
        end else if (w_shift) begin
            r_step <= w_last_step ? '0 : r_step + IDX_W'(1);
            if (w_record) begin
                r_held_valid <= 1'b1;
                r_count      <= r_count + RES_W'(1);
            end
            if (r_action == ACT_QUERY && w_ctl.hit) begin
                r_alive <= w_cell_q[0].armed;
            end
        end else if (w_push_final) begin
            r_held_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_in.payload.action;
            r_id_ok  <= (w_id < 32'(r_tiu)) && (w_id < 32'(NUM_TIMERS));
            r_slot   <= w_id[IDX_W-1:0];
            r_start  <= i_in.payload.start_value;
            r_cycle  <= i_in.payload.cycle_value;
        end
        if (w_shift && w_record) begin
            r_held_idx <= w_step32[3:0];
        end
    end

    // output register: a held fired beat leaves when the next one shows up, or as the final result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_held || w_push_final) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_held) begin
            r_out <= '{kind: KIND_FIRED, which_timer: r_held_idx, alive: 1'b0, last: 1'b0};
        end else if (w_push_final) begin
            if (r_held_valid) begin
                r_out <= '{kind: KIND_FIRED, which_timer: r_held_idx, alive: 1'b0,
                           last: 1'b1};
            end else if (r_action == ACT_QUERY) begin
                r_out <= '{kind: KIND_QUERY, which_timer: 4'd0, alive: r_alive,
                           last: 1'b1};
            end else begin
                r_out <= '{kind: KIND_ACK, which_timer: 4'd0, alive: 1'b0, last: 1'b1};
            end
        end
    end

    assign i_in.ready    = w_in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

/* rtl/stb_cell.sv */
module stb_cell
    import stb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_slot,
    output t_slot o_slot
);

    logic        r_armed;
    logic [31:0] r_remaining;
    logic [31:0] r_reload;

    // armed bit clears on reset, counts stay undefined until a restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
        end else if (i_shift) begin
            r_armed <= i_slot.armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_remaining <= i_slot.remaining;
            r_reload    <= i_slot.reload;
        end
    end

    assign o_slot = '{armed: r_armed, remaining: r_remaining, reload: r_reload};

endmodule

/* rtl/stb_proc.sv */
module stb_proc
    import stb_pkg::*;
(
    input  t_head_ctl   i_ctl,
    input  t_slot       i_slot,
    input  logic [31:0] i_tick_step,
    input  logic [31:0] i_start_value,
    input  logic [31:0] i_cycle_value,
    output t_slot       o_slot,
    output logic        o_fire
);

    // update of the timer passing the head of the ring
    always_comb begin
        o_slot = i_slot;
        o_fire = 1'b0;
        unique case (i_ctl.action)
            ACT_TICK: begin
                if (i_ctl.in_use && i_slot.armed) begin
                    if (i_slot.remaining == '0) begin
                        o_fire = 1'b1;
                        if (i_slot.reload == '0) begin
                            o_slot.armed = 1'b0;
                        end else begin
                            o_slot.remaining = i_slot.reload;
                        end
                    end else if (i_slot.remaining > i_tick_step) begin
                        o_slot.remaining = i_slot.remaining - i_tick_step;
                    end else begin
                        o_slot.remaining = '0;
                    end
                end
            end
            ACT_RESTART: begin
                if (i_ctl.hit) begin
                    o_slot.armed     = 1'b1;
                    o_slot.remaining = i_start_value;
                    o_slot.reload    = i_cycle_value;
                end
            end
            ACT_KILL: begin
                if (i_ctl.hit) begin
                    o_slot.armed = 1'b0;
                end
            end
            ACT_QUERY: begin
                o_slot = i_slot;
            end
            default: begin
                o_slot = i_slot;
            end
        endcase
    end

endmodule

/* rtl/stb_checker.sv */
`include "software_timer_bank_top_defines.svh"

module stb_checker
    import stb_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    stb_stream_if.sink   i_in,
    stb_stream_if.source o_out
);

    // a stalled result beat holds
    `STB_CHECK_NEXT(a_out_hold, o_out.valid && !o_out.ready, o_out.valid && $stable(o_out.payload), "stalled result beat changed")

    // one item at a time: no second beat right after an accept
    `STB_CHECK_NEXT(a_one_item, i_in.valid && i_in.ready, !i_in.ready, "input ready right after accept")

    // while ready for a new item, any waiting result closes the previous one
    `STB_CHECK(a_idle_last, i_in.ready && o_out.valid, o_out.payload.last, "idle with a non-final result pending")

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
